// ===== rtl/core/lbl_pkg.sv =====
`default_nettype none

package lbl_pkg;

    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 2;
    localparam int LED_WORD_W = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int UPC_W      = 4;

    // Request codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_LED_SET = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INIT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PACKET  = 2'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OP_LED_SET,
        REG_OP_LED_USER,
        REG_OP_IRQ_ON,
        REG_RSP_BUTTON,
        REG_RSP_ACK,
        REG_RSP_RESET
    } t_reg_idx;

    localparam logic [BYTE_W-1:0] FRAME_MARK = 8'h0F;
    localparam logic [BYTE_W-1:0] DP_BIT     = 8'h10;
    localparam logic [BYTE_W-1:0] BTN_ALL_UP = 8'hFF;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [LED_WORD_W-1:0] led_word;
        logic [BYTE_W-1:0]     pkt_first;
        logic [BYTE_W-1:0]     pkt_second;
        logic [BYTE_W-1:0]     pkt_third;
    } t_in_word;

    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              run_last;
        logic [BYTE_W-1:0] buttons;
        logic              was_busy;
    } t_out_word;

    // Microcode control word: what to send, whether the step repeats, and
    // whether it ends the program.
    typedef enum logic [2:0] {
        SRC_STATUS,
        SRC_IRQ_ON,
        SRC_LED_USER,
        SRC_LED_SET,
        SRC_FRAME_MARK,
        SRC_GLYPH_ZERO,
        SRC_STORE
    } t_src;

    typedef enum logic [1:0] {
        REP_NONE,
        REP_DIGITS,
        REP_STORE
    } t_rep;

    typedef enum logic [1:0] {
        FIN_NO,
        FIN_YES,
        FIN_IF_EMPTY
    } t_fin;

    typedef struct packed {
        t_src src;
        t_rep rep;
        t_fin fin;
    } t_uword;

    // Program entry points.
    localparam logic [UPC_W-1:0] UPC_STATUS = 4'd0;
    localparam logic [UPC_W-1:0] UPC_INIT   = 4'd1;
    localparam logic [UPC_W-1:0] UPC_LED    = 4'd6;
    localparam logic [UPC_W-1:0] UPC_RESET  = 4'd7;

    function automatic t_uword uc_fetch(input logic [UPC_W-1:0] upc);
        t_uword uw;
        case (upc)
            4'd0:    uw = '{SRC_STATUS,     REP_NONE,   FIN_YES};
            4'd1:    uw = '{SRC_IRQ_ON,     REP_NONE,   FIN_NO};
            4'd2:    uw = '{SRC_LED_USER,   REP_NONE,   FIN_NO};
            4'd3:    uw = '{SRC_LED_SET,    REP_NONE,   FIN_NO};
            4'd4:    uw = '{SRC_FRAME_MARK, REP_NONE,   FIN_NO};
            4'd5:    uw = '{SRC_GLYPH_ZERO, REP_DIGITS, FIN_YES};
            4'd6:    uw = '{SRC_STORE,      REP_STORE,  FIN_YES};
            4'd7:    uw = '{SRC_LED_USER,   REP_NONE,   FIN_NO};
            4'd8:    uw = '{SRC_IRQ_ON,     REP_NONE,   FIN_IF_EMPTY};
            4'd9:    uw = '{SRC_STORE,      REP_STORE,  FIN_YES};
            default: uw = '{SRC_STATUS,     REP_NONE,   FIN_YES};
        endcase
        return uw;
    endfunction

    function automatic logic [BYTE_W-1:0] glyph(input logic [3:0] digit);
        logic [BYTE_W-1:0] g;
        case (digit)
            4'h0:    g = 8'hE7;
            4'h1:    g = 8'h06;
            4'h2:    g = 8'hCB;
            4'h3:    g = 8'h8F;
            4'h4:    g = 8'h2E;
            4'h5:    g = 8'hAD;
            4'h6:    g = 8'hED;
            4'h7:    g = 8'h86;
            4'h8:    g = 8'hEF;
            4'h9:    g = 8'hAE;
            4'hA:    g = 8'hEE;
            4'hB:    g = 8'h6D;
            4'hC:    g = 8'hE1;
            4'hD:    g = 8'h4F;
            4'hE:    g = 8'hE9;
            default: g = 8'hE8;
        endcase
        return g;
    endfunction

    // Low nibble of the second byte, then the low nibble of the third with its
    // bits 1 and 2 swapped into bits 6 and 5.
    function automatic logic [BYTE_W-1:0] remap_buttons(input logic [BYTE_W-1:0] second,
                                                        input logic [BYTE_W-1:0] third);
        return {third[3], third[1], third[2], third[0], second[3:0]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lbl_stream_if.sv =====
`default_nettype none

interface lbl_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/led_button_link_controller.sv =====
`default_nettype none

// Channel   Dir  Word        Notes
// i_in      in   t_in_word   request or received packet, one per word
// o_out     out  t_out_word  one word per byte sent, or one status word
// i_cfg_*   in   8-bit data  register write, index 0..5, no read-back
//
// A word taken on i_in picks the program and updates the link state; the
// sequencer then loads one result word per cycle into the output register,
// unless o_out stalls, for N results (1 to DIGIT_COUNT + 4: six for a set-LED
// request, eight for an init or a replay, two for a replay of an empty frame).
// A stall on o_out holds the current step; i_in is taken again once the last
// word of a run is in the output register. Synchronous reset frees the link,
// clears the button byte and empties the replay frame.

module led_button_link_controller #(
    parameter int DIGIT_COUNT = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [lbl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lbl_pkg::BYTE_W-1:0]    i_cfg_data,
    lbl_stream_if.sink                        i_in,
    lbl_stream_if.source                      o_out
);
    import lbl_pkg::*;

    // The replay frame is the opcode, the frame mark and one segment byte
    // for each digit.
    localparam int STORE_DEPTH = DIGIT_COUNT + 2;
    localparam int CNT_W       = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
    localparam int WIDE_W      = 32;

    // Configuration registers.
    logic [BYTE_W-1:0] r_op_led_set;
    logic [BYTE_W-1:0] r_op_led_user;
    logic [BYTE_W-1:0] r_op_irq_on;
    logic [BYTE_W-1:0] r_rsp_button;
    logic [BYTE_W-1:0] r_rsp_ack;
    logic [BYTE_W-1:0] r_rsp_reset;

    // Link state.
    logic [BYTE_W-1:0] r_buttons;
    logic              r_busy;
    logic [BYTE_W-1:0] r_store [STORE_DEPTH];
    logic [LEN_W-1:0]  r_len;

    // Sequencer.
    logic              r_run;
    logic [UPC_W-1:0]  r_upc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_was_busy;

    // Output register.
    logic              r_out_valid;
    t_out_word         r_out;

    t_in_word          w_in;
    logic              w_in_acc;
    logic              w_step;
    t_uword            w_uw;
    logic [LEN_W-1:0]  w_limit;
    logic              w_rep_done;
    logic              w_last;
    logic [BYTE_W-1:0] w_byte;
    logic [WIDE_W-1:0] w_wide;
    logic [BYTE_W-1:0] w_seg [DIGIT_COUNT];
    logic [UPC_W-1:0]  n_upc;
    logic              n_busy;
    logic              n_was_busy;

    assign w_in     = i_in.payload;
    assign w_in_acc = i_in.valid && !r_run;
    assign w_step   = r_run && (!r_out_valid || o_out.ready);

    assign i_in.ready    = !r_run;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // Segment bytes of a set-LED request. Bits above the led_word field
    // read as zero, which matters only for wide displays.
    assign w_wide = {{(WIDE_W - LED_WORD_W){1'b0}}, w_in.led_word};

    always_comb begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            w_seg[i] = w_wide[16 + i] ? glyph(w_wide[4 * i +: 4]) : '0;
            if (w_wide[24 + i]) begin
                w_seg[i] = w_seg[i] | DP_BIT;
            end
        end
    end

    // Dispatch: choose the program and the link state after this word.
    always_comb begin
        n_upc      = UPC_STATUS;
        n_busy     = r_busy;
        n_was_busy = 1'b0;
        unique case (w_in.mode) inside
            MODE_LED_SET, MODE_INIT: begin
                if (r_busy) begin
                    n_was_busy = 1'b1;
                end else begin
                    n_upc  = (w_in.mode == MODE_LED_SET) ? UPC_LED : UPC_INIT;
                    n_busy = 1'b1;
                end
            end
            MODE_PACKET: begin
                if (w_in.pkt_first == r_rsp_button) begin
                    n_upc = UPC_STATUS;
                end else if (w_in.pkt_first == r_rsp_ack) begin
                    n_busy = 1'b0;
                end else if (w_in.pkt_first == r_rsp_reset) begin
                    if (r_busy) begin
                        n_was_busy = 1'b1;
                    end else begin
                        n_upc  = UPC_RESET;
                        n_busy = 1'b1;
                    end
                end
            end
            default: begin
                n_upc = UPC_STATUS;
            end
        endcase
    end

    // Datapath driven by the current control word.
    assign w_uw = uc_fetch(r_upc);

    always_comb begin
        case (w_uw.rep)
            REP_DIGITS: w_limit = LEN_W'(DIGIT_COUNT - 1);
            REP_STORE:  w_limit = r_len - LEN_W'(1);
            default:    w_limit = '0;
        endcase
    end

    assign w_rep_done = (w_uw.rep == REP_NONE) || (LEN_W'(r_cnt) == w_limit);
    assign w_last     = w_rep_done &&
                        ((w_uw.fin == FIN_YES) ||
                         ((w_uw.fin == FIN_IF_EMPTY) && (r_len == '0)));

    always_comb begin
        case (w_uw.src)
            SRC_IRQ_ON:     w_byte = r_op_irq_on;
            SRC_LED_USER:   w_byte = r_op_led_user;
            SRC_LED_SET:    w_byte = r_op_led_set;
            SRC_FRAME_MARK: w_byte = FRAME_MARK;
            SRC_GLYPH_ZERO: w_byte = glyph(4'h0);
            SRC_STORE:      w_byte = r_store[r_cnt];
            default:        w_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_led_set  <= 8'd70;
            r_op_led_user <= 8'd73;
            r_op_irq_on   <= 8'd67;
            r_rsp_button  <= 8'd65;
            r_rsp_ack     <= 8'd64;
            r_rsp_reset   <= 8'd66;
            r_buttons     <= '0;
            r_busy        <= 1'b0;
            r_len         <= '0;
            r_run         <= 1'b0;
            r_upc         <= UPC_STATUS;
            r_cnt         <= '0;
            r_was_busy    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // The user must write registers only while the block is idle; the block itself does not enforce this.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OP_LED_SET:  r_op_led_set  <= i_cfg_data;
                    REG_OP_LED_USER: r_op_led_user <= i_cfg_data;
                    REG_OP_IRQ_ON:   r_op_irq_on   <= i_cfg_data;
                    REG_RSP_BUTTON:  r_rsp_button  <= i_cfg_data;
                    REG_RSP_ACK:     r_rsp_ack     <= i_cfg_data;
                    REG_RSP_RESET:   r_rsp_reset   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (w_in_acc) begin
                r_run      <= 1'b1;
                r_upc      <= n_upc;
                r_cnt      <= '0;
                r_busy     <= n_busy;
                r_was_busy <= n_was_busy;
                if (n_upc == UPC_LED) begin
                    r_store[0] <= r_op_led_set;
                    r_store[1] <= FRAME_MARK;
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        r_store[2 + i] <= w_seg[i];
                    end
                    r_len <= LEN_W'(STORE_DEPTH);
                end
                if (w_in.mode == MODE_PACKET) begin
                    if (w_in.pkt_first == r_rsp_button) begin
                        r_buttons <= remap_buttons(w_in.pkt_second, w_in.pkt_third);
                    end else if (n_upc == UPC_RESET) begin
                        r_buttons <= BTN_ALL_UP;
                    end
                end
            end

            if (w_step) begin
                r_out_valid <= 1'b1;
                if (!w_rep_done) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end else if (w_last) begin
                    r_run <= 1'b0;
                end else begin
                    r_upc <= r_upc + UPC_W'(1);
                    r_cnt <= '0;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload; needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out.byte_valid <= (w_uw.src != SRC_STATUS);
            r_out.tx_byte    <= w_byte;
            r_out.run_last   <= w_last;
            r_out.buttons    <= r_buttons;
            r_out.was_busy   <= (w_uw.src == SRC_STATUS) && r_was_busy;
        end
    end

endmodule

`default_nettype wire
